/* hdl/ctok_pkg.sv */
// Shared types, codes and constants for the C-subset tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package ctok_pkg;

  localparam int MAX_TEXT = 32;
  localparam int IDX_W    = $clog2(MAX_TEXT);
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);
  localparam int NUM_W    = 31;
  localparam int KIND_W   = 5;
  localparam int TIDX_W   = 5;
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [KIND_W-1:0] {
    K_STRING  = 5'd0,
    K_PRINTF  = 5'd1,
    K_RETURN  = 5'd2,
    K_INT     = 5'd3,
    K_IF      = 5'd4,
    K_IDENT   = 5'd5,
    K_NUMBER  = 5'd6,
    K_SEMI    = 5'd7,
    K_LBRACE  = 5'd8,
    K_RBRACE  = 5'd9,
    K_LBRACK  = 5'd10,
    K_RBRACK  = 5'd11,
    K_LPAREN  = 5'd12,
    K_RPAREN  = 5'd13,
    K_ASSIGN  = 5'd14,
    K_LESS    = 5'd15,
    K_GREATER = 5'd16,
    K_UNKNOWN = 5'd17
  } kind_t;

  typedef enum logic [2:0] {
    C_SPACE,
    C_NEWLINE,
    C_HASH,
    C_QUOTE,
    C_LETTER,
    C_DIGIT,
    C_PUNCT,
    C_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    OSEL_TOKEN,
    OSEL_EMPTY,
    OSEL_UNKNOWN,
    OSEL_NUM,
    OSEL_TEXT
  } osel_t;

  // Controller -> datapath
  typedef struct packed {
    logic  hold_byte;
    logic  clear_run;
    logic  append;
    logic  add_digit;
    logic  idx_clr;
    logic  idx_inc;
    logic  out_load;
    osel_t out_sel;
    kind_t out_kind;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    cls_t  cls;
    kind_t punct_kind;
    kind_t kw_kind;
    logic  len_zero;
    logic  idx_last;
    logic  out_free;
  } stat_t;

  function automatic cls_t byte_class(input logic [7:0] b);
    cls_t c;
    c = C_OTHER;
    if (b == CH_SPACE) c = C_SPACE;
    else if (b == CH_NL) c = C_NEWLINE;
    else if (b == CH_HASH) c = C_HASH;
    else if (b == CH_QUOTE) c = C_QUOTE;
    else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) c = C_LETTER;
    else if (b >= 8'h30 && b <= 8'h39) c = C_DIGIT;
    else begin
      case (b)
        8'h3B, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
        8'h28, 8'h29, 8'h3D, 8'h3C, 8'h3E: c = C_PUNCT;
        default: c = C_OTHER;
      endcase
    end
    return c;
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      8'h3B:   k = K_SEMI;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h5B:   k = K_LBRACK;
      8'h5D:   k = K_RBRACK;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h3D:   k = K_ASSIGN;
      8'h3C:   k = K_LESS;
      8'h3E:   k = K_GREATER;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* hdl/ctok_dp.sv */
// Tokenizer datapath: text store, digit accumulator, keyword match, output register.
`timescale 1ns / 1ps
`default_nettype none
module ctok_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [7:0]                  in_byte,
  input  wire ctok_pkg::cmd_t              cmd,
  output ctok_pkg::stat_t                  stat,
  input  wire logic                        out_tready,
  output logic                             out_tvalid,
  output logic [47:0]                      out_tdata,
  output logic [ctok_pkg::KIND_W-1:0]      out_tuser,
  output logic                             out_tlast
);

  logic [7:0]                    store_r [ctok_pkg::MAX_TEXT];
  logic [7:0]                    held_r;
  logic                          held_sel_r, held_sel_nxt;
  logic [ctok_pkg::LEN_W-1:0]    len_r, len_nxt, len_base;
  logic [ctok_pkg::NUM_W-1:0]    acc_r, acc_nxt, acc_base;
  logic                          ovf_r, ovf_nxt, ovf_base;
  logic [ctok_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [7:0]                    cur_byte;
  logic [34:0]                   acc_ten;
  logic                          kw_ok6, kw_ok3, kw_ok2;

  logic                          out_valid_r, out_valid_nxt;
  ctok_pkg::kind_t               o_kind_r, o_kind_nxt;
  logic [ctok_pkg::NUM_W-1:0]    o_num_r, o_num_nxt;
  logic [7:0]                    o_char_r, o_char_nxt;
  logic                          o_tv_r, o_tt_r, o_sat_r, o_last_r;
  logic                          o_tv_nxt, o_tt_nxt, o_sat_nxt, o_last_nxt;
  logic [ctok_pkg::TIDX_W-1:0]   o_idx_r, o_idx_nxt;

  // The held byte is selected from the transaction that ended a run until the run restarts
  assign cur_byte = held_sel_r ? held_r : in_byte;

  // Run state after an optional restart, then this transaction's update
  always_comb begin
    len_base = cmd.clear_run ? '0 : len_r;
    acc_base = cmd.clear_run ? '0 : acc_r;
    ovf_base = cmd.clear_run ? 1'b0 : ovf_r;
    len_nxt  = len_base;
    acc_nxt  = acc_base;
    ovf_nxt  = ovf_base;
    acc_ten  = (35'(acc_base) << 3) + (35'(acc_base) << 1) + 35'(cur_byte[3:0]);
    if (cmd.append) begin
      if (len_base < ctok_pkg::LEN_W'(ctok_pkg::MAX_TEXT)) len_nxt = len_base + 1'b1;
      else ovf_nxt = 1'b1;
    end
    if (cmd.add_digit) begin
      if (acc_ten > 35'(ctok_pkg::NUM_MAX)) begin
        acc_nxt = ctok_pkg::NUM_MAX;
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = acc_ten[ctok_pkg::NUM_W-1:0];
      end
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + 1'b1;
    if (cmd.hold_byte) held_sel_nxt = 1'b1;
    else if (cmd.clear_run) held_sel_nxt = 1'b0;
    else held_sel_nxt = held_sel_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.append && len_base < ctok_pkg::LEN_W'(ctok_pkg::MAX_TEXT)) begin
      store_r[len_base[ctok_pkg::IDX_W-1:0]] <= cur_byte;
    end
    if (cmd.hold_byte) held_r <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      acc_r      <= '0;
      ovf_r      <= 1'b0;
      idx_r      <= '0;
      held_sel_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      acc_r      <= acc_nxt;
      ovf_r      <= ovf_nxt;
      idx_r      <= idx_nxt;
      held_sel_r <= held_sel_nxt;
    end
  end

  // Keyword match looks only at entries below the run length
  assign kw_ok6 = !ovf_r && len_r == ctok_pkg::LEN_W'(6);
  assign kw_ok3 = !ovf_r && len_r == ctok_pkg::LEN_W'(3);
  assign kw_ok2 = !ovf_r && len_r == ctok_pkg::LEN_W'(2);

  always_comb begin
    stat.kw_kind = ctok_pkg::K_IDENT;
    if (kw_ok6 && store_r[0] == "p" && store_r[1] == "r" && store_r[2] == "i" &&
        store_r[3] == "n" && store_r[4] == "t" && store_r[5] == "f")
      stat.kw_kind = ctok_pkg::K_PRINTF;
    else if (kw_ok6 && store_r[0] == "r" && store_r[1] == "e" && store_r[2] == "t" &&
             store_r[3] == "u" && store_r[4] == "r" && store_r[5] == "n")
      stat.kw_kind = ctok_pkg::K_RETURN;
    else if (kw_ok3 && store_r[0] == "i" && store_r[1] == "n" && store_r[2] == "t")
      stat.kw_kind = ctok_pkg::K_INT;
    else if (kw_ok2 && store_r[0] == "i" && store_r[1] == "f")
      stat.kw_kind = ctok_pkg::K_IF;
    stat.cls        = ctok_pkg::byte_class(cur_byte);
    stat.punct_kind = ctok_pkg::punct_kind(cur_byte);
    stat.len_zero   = (len_r == '0);
    stat.idx_last   = (ctok_pkg::LEN_W'(idx_r) + 1'b1 == len_r);
    stat.out_free   = !out_valid_r || out_tready;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_comb begin
    o_kind_nxt = o_kind_r;
    o_num_nxt  = o_num_r;
    o_char_nxt = o_char_r;
    o_tv_nxt   = o_tv_r;
    o_idx_nxt  = o_idx_r;
    o_tt_nxt   = o_tt_r;
    o_sat_nxt  = o_sat_r;
    o_last_nxt = o_last_r;
    if (cmd.out_load) begin
      o_kind_nxt = cmd.out_kind;
      o_num_nxt  = '0;
      o_char_nxt = '0;
      o_tv_nxt   = 1'b0;
      o_idx_nxt  = '0;
      o_tt_nxt   = 1'b0;
      o_sat_nxt  = 1'b0;
      o_last_nxt = 1'b1;
      case (cmd.out_sel)
        ctok_pkg::OSEL_TOKEN: ;
        ctok_pkg::OSEL_EMPTY: o_tt_nxt = ovf_r;
        ctok_pkg::OSEL_UNKNOWN: begin
          o_char_nxt = cur_byte;
          o_tv_nxt   = 1'b1;
        end
        ctok_pkg::OSEL_NUM: begin
          o_num_nxt = acc_r;
          o_sat_nxt = ovf_r;
        end
        ctok_pkg::OSEL_TEXT: begin
          o_char_nxt = store_r[idx_r];
          o_tv_nxt   = 1'b1;
          o_idx_nxt  = ctok_pkg::TIDX_W'(idx_r);
          o_tt_nxt   = ovf_r;
          o_last_nxt = stat.idx_last;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    o_kind_r <= o_kind_nxt;
    o_num_r  <= o_num_nxt;
    o_char_r <= o_char_nxt;
    o_tv_r   <= o_tv_nxt;
    o_idx_r  <= o_idx_nxt;
    o_tt_r   <= o_tt_nxt;
    o_sat_r  <= o_sat_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, o_sat_r, o_tt_r, o_idx_r, o_tv_r, o_char_r, o_num_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

/* hdl/ctok_ctrl.sv */
// Tokenizer controller: scan mode and transaction sequencing.
`timescale 1ns / 1ps
`default_nettype none
module ctok_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_tlast,
  output logic                 in_tready,
  input  wire ctok_pkg::stat_t stat,
  output ctok_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IN   = 3'b001,
    ST_EMIT = 3'b010,
    ST_POST = 3'b100
  } state_t;

  typedef enum logic [4:0] {
    M_IDLE    = 5'b00001,
    M_COMMENT = 5'b00010,
    M_STRING  = 5'b00100,
    M_WORD    = 5'b01000,
    M_NUMBER  = 5'b10000
  } mode_t;

  state_t          st_r, st_nxt;
  mode_t           mode_r, mode_nxt, idle_mode;
  logic            pend_r, pend_nxt;
  ctok_pkg::kind_t ekind_r, ekind_nxt;
  ctok_pkg::cmd_t  idle_cmd;
  logic            in_fire;

  assign in_tready = (st_r == ST_IN) && stat.out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Handling of a byte seen from the idle mode (current byte or the held one)
  always_comb begin
    idle_cmd           = '0;
    idle_cmd.clear_run = 1'b1;
    idle_cmd.out_kind  = ctok_pkg::K_UNKNOWN;
    idle_cmd.out_sel   = ctok_pkg::OSEL_TOKEN;
    idle_mode          = M_IDLE;
    case (stat.cls)
      ctok_pkg::C_SPACE, ctok_pkg::C_NEWLINE: ;
      ctok_pkg::C_HASH:  idle_mode = M_COMMENT;
      ctok_pkg::C_QUOTE: idle_mode = M_STRING;
      ctok_pkg::C_LETTER: begin
        idle_mode       = M_WORD;
        idle_cmd.append = 1'b1;
      end
      ctok_pkg::C_DIGIT: begin
        idle_mode          = M_NUMBER;
        idle_cmd.add_digit = 1'b1;
      end
      ctok_pkg::C_PUNCT: begin
        idle_cmd.out_load = 1'b1;
        idle_cmd.out_kind = stat.punct_kind;
      end
      default: begin
        idle_cmd.out_load = 1'b1;
        idle_cmd.out_sel  = ctok_pkg::OSEL_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    st_nxt       = st_r;
    mode_nxt     = mode_r;
    pend_nxt     = pend_r;
    ekind_nxt    = ekind_r;
    cmd          = '0;
    cmd.out_kind = ctok_pkg::K_UNKNOWN;
    cmd.out_sel  = ctok_pkg::OSEL_TOKEN;
    case (st_r)
      ST_IN: begin
        if (in_fire) begin
          if (in_tlast) begin
            mode_nxt      = M_IDLE;
            cmd.clear_run = 1'b1;
            case (mode_r)
              M_WORD: begin
                if (stat.kw_kind != ctok_pkg::K_IDENT) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = stat.kw_kind;
                end else begin
                  cmd.clear_run = 1'b0;
                  cmd.idx_clr   = 1'b1;
                  ekind_nxt     = ctok_pkg::K_IDENT;
                  pend_nxt      = 1'b0;
                  st_nxt        = ST_EMIT;
                end
              end
              M_STRING: begin
                if (stat.len_zero) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = ctok_pkg::OSEL_EMPTY;
                  cmd.out_kind = ctok_pkg::K_STRING;
                end else begin
                  cmd.clear_run = 1'b0;
                  cmd.idx_clr   = 1'b1;
                  ekind_nxt     = ctok_pkg::K_STRING;
                  pend_nxt      = 1'b0;
                  st_nxt        = ST_EMIT;
                end
              end
              M_NUMBER: begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = ctok_pkg::OSEL_NUM;
                cmd.out_kind = ctok_pkg::K_NUMBER;
              end
              default: ;
            endcase
          end else begin
            case (mode_r)
              M_COMMENT: begin
                if (stat.cls == ctok_pkg::C_NEWLINE) mode_nxt = M_IDLE;
              end
              M_STRING: begin
                if (stat.cls == ctok_pkg::C_QUOTE) begin
                  mode_nxt = M_IDLE;
                  if (stat.len_zero) begin
                    cmd.clear_run = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = ctok_pkg::OSEL_EMPTY;
                    cmd.out_kind  = ctok_pkg::K_STRING;
                  end else begin
                    cmd.idx_clr = 1'b1;
                    ekind_nxt   = ctok_pkg::K_STRING;
                    pend_nxt    = 1'b0;
                    st_nxt      = ST_EMIT;
                  end
                end else begin
                  cmd.append = 1'b1;
                end
              end
              M_WORD: begin
                if (stat.cls == ctok_pkg::C_LETTER) begin
                  cmd.append = 1'b1;
                end else begin
                  // word ends here; the terminating byte is replayed afterwards
                  mode_nxt      = M_IDLE;
                  cmd.hold_byte = 1'b1;
                  if (stat.kw_kind != ctok_pkg::K_IDENT) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = stat.kw_kind;
                    st_nxt       = ST_POST;
                  end else begin
                    cmd.idx_clr = 1'b1;
                    ekind_nxt   = ctok_pkg::K_IDENT;
                    pend_nxt    = 1'b1;
                    st_nxt      = ST_EMIT;
                  end
                end
              end
              M_NUMBER: begin
                if (stat.cls == ctok_pkg::C_DIGIT) begin
                  cmd.add_digit = 1'b1;
                end else begin
                  mode_nxt      = M_IDLE;
                  cmd.hold_byte = 1'b1;
                  cmd.out_load  = 1'b1;
                  cmd.out_sel   = ctok_pkg::OSEL_NUM;
                  cmd.out_kind  = ctok_pkg::K_NUMBER;
                  st_nxt        = ST_POST;
                end
              end
              default: begin
                cmd      = idle_cmd;
                mode_nxt = idle_mode;
              end
            endcase
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = ctok_pkg::OSEL_TEXT;
          cmd.out_kind = ekind_r;
          cmd.idx_inc  = 1'b1;
          if (stat.idx_last) begin
            if (pend_r) begin
              st_nxt = ST_POST;
            end else begin
              cmd.clear_run = 1'b1;
              st_nxt        = ST_IN;
            end
          end
        end
      end
      ST_POST: begin
        if (stat.out_free) begin
          cmd          = idle_cmd;
          mode_nxt     = idle_mode;
          pend_nxt     = 1'b0;
          st_nxt       = ST_IN;
        end
      end
      default: st_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IN;
      mode_r  <= M_IDLE;
      pend_r  <= 1'b0;
      ekind_r <= ctok_pkg::K_IDENT;
    end else begin
      st_r    <= st_nxt;
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      ekind_r <= ekind_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/c_subset_tokenizer_unit.sv */
// Top level of the byte-serial C-subset tokenizer.
//
//  channel | dir | tdata                          | tuser     | tlast
//  in_     | in  | byte_in[7:0]                   | -         | end_of_input
//  out_    | out | number_value, text_char, ...   | kind[4:0] | last_of_token
//
// A byte that starts, extends or drops a run, or is punctuation or unknown
// seen from idle, is handled in the accepting cycle. A byte that ends a word
// or number is held and replayed from idle once the output is free. A text
// token sends one character per cycle (up to 32) while output is free; the
// single output register and one-read-per-cycle text store set this rate.
// Reset (rst_n low, synchronous) returns the scan mode to idle and empties
// the output register. A stalled output holds off new input transactions.
`timescale 1ns / 1ps
`default_nettype none
module c_subset_tokenizer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] byte_in
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [30:0] number_value, [38:31] text_char, [39] text_valid, [44:40] text_index,
  // [45] text_truncated, [46] number_saturated, [47] zero
  output logic [47:0]                      out_tdata,
  output logic [ctok_pkg::KIND_W-1:0]      out_tuser,  // [4:0] kind
  output logic                             out_tlast
);

  ctok_pkg::cmd_t  cmd;
  ctok_pkg::stat_t stat;

  ctok_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ctok_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* hdl/ctok_chk.sv */
// Port-level checker for the tokenizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ctok_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic [7:0]                  in_tdata,
  input wire logic                        in_tlast,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [47:0]                 out_tdata,
  input wire logic [ctok_pkg::KIND_W-1:0] out_tuser,
  input wire logic                        out_tlast
);

  // A stalled result transaction keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Kind never exceeds the unknown code
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ctok_pkg::K_UNKNOWN)
    else $error("kind out of range");

  // No text character means zero character and zero index
  a_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[39] |-> out_tdata[38:31] == 8'd0 && out_tdata[44:40] == 5'd0)
    else $error("stray text fields");

  // Only number tokens carry a value or a saturation flag
  a_num_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ctok_pkg::K_NUMBER |->
      out_tdata[30:0] == 31'd0 && !out_tdata[46])
    else $error("number fields on non-number token");

  // Input is held off while a result waits and is not taken
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

endmodule

bind c_subset_tokenizer_unit ctok_chk u_ctok_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
